/* src/rsa_pkg.sv */
package rsa_pkg;

    typedef struct packed {
        logic signed [31:0] numerator;
        logic [30:0]        denominator;
        logic               last_item;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] sum_numerator;
        logic signed [31:0] sum_denominator;
        logic               overflow;
    } t_out_word;

    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [31:0] rem;
    } t_div_rsp;

endpackage

/* src/rsa_div.sv */
module rsa_div
    import rsa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_q, n_q;
    logic [31:0] r_r, n_r;
    logic [31:0] r_d, n_d;
    logic        r_qneg, n_qneg, r_rneg, n_rneg, r_zero, n_zero;
    logic [31:0] r_a, n_a;
    logic        r_done, n_done;
    logic [32:0] trial;
    logic [31:0] ua, ub;

    always_comb begin
        ua = i_req.a[31] ? (~i_req.a + 32'd1) : i_req.a;
        ub = i_req.b[31] ? (~i_req.b + 32'd1) : i_req.b;
        trial = {r_r, r_q[31]} - {1'b0, r_d};
        n_busy = r_busy; n_cnt = r_cnt; n_q = r_q; n_r = r_r; n_d = r_d;
        n_qneg = r_qneg; n_rneg = r_rneg; n_zero = r_zero; n_a = r_a;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1; n_cnt = 6'd0; n_q = ua; n_r = '0; n_d = ub;
            n_qneg = i_req.a[31] ^ i_req.b[31]; n_rneg = i_req.a[31];
            n_zero = (i_req.b == '0); n_a = i_req.a;
        end else if (r_busy) begin
            if (!trial[32]) begin
                n_r = trial[31:0];
                n_q = {r_q[30:0], 1'b1};
            end else begin
                n_r = {r_r[30:0], r_q[31]};
                n_q = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q; r_r <= n_r; r_d <= n_d; r_a <= n_a;
        r_qneg <= n_qneg; r_rneg <= n_rneg; r_zero <= n_zero;
    end

    always_comb begin
        o_rsp.done = r_done;
        if (r_zero) begin
            o_rsp.quo = r_a;
            o_rsp.rem = r_a;
        end else begin
            o_rsp.quo = r_qneg ? (~r_q + 32'd1) : r_q;
            o_rsp.rem = r_rneg ? (~r_r + 32'd1) : r_r;
        end
    end
endmodule

/* src/rational_sum_accumulator_top.sv */
// Channel | Direction | Payload     | Handshake
// in      | input     | t_in_word   | i_in_valid / o_in_stall
// out     | output    | t_out_word  | o_out_valid / i_out_stall
// First word of a group: it is stored and goes straight to the finish state. A
// later word: two Euclid loops, five bit-serial divisions and three shift-add
// multiplies, the first multiply running under the first Euclid loop.
// Reset is synchronous and clears the control state and the sum.
// A waiting result holds back only the next result, not the next word.
module rational_sum_accumulator_top
    import rsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out
);
    typedef enum logic [4:0] {
        S_IDLE, S_G1, S_G1W, S_MUL1, S_LCM, S_LCMW, S_F1W, S_F2W,
        S_M2, S_M3, S_G2, S_G2W, S_DN, S_DNW, S_DDW, S_FIN
    } t_state;

    t_state      r_state;
    logic [31:0] r_n1, r_d1, r_n2, r_d2;
    logic [31:0] r_ga, r_gb, r_prod, r_lcm, r_f1, r_f2, r_num, r_g, r_tmp;
    logic [31:0] r_ma, r_mb, r_macc;
    logic [5:0]  r_mcnt;
    logic        r_mbusy, r_open, r_ovf, r_last;
    t_div_req    r_req;
    t_div_rsp    w_rsp;
    t_out_word   r_out;
    logic        r_ovalid;
    logic        n_start;

    rsa_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_req), .o_rsp(w_rsp));

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    always_comb begin
        unique case (r_state)
            S_G1, S_G2:           n_start = (r_gb != '0);
            S_LCM, S_DN:          n_start = 1'b1;
            S_LCMW, S_F1W, S_DNW: n_start = w_rsp.done;
            default:              n_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_open  <= 1'b0;
            r_ovf   <= 1'b0;
            r_ovalid <= 1'b0;
            r_mbusy <= 1'b0;
            r_req.start <= 1'b0;
            r_n1 <= '0;
            r_d1 <= 32'd1;
        end else begin
            r_req.start <= n_start;
            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            if (r_mbusy) begin
                if (r_mb[0]) r_macc <= r_macc + r_ma;
                r_ma <= {r_ma[30:0], 1'b0};
                r_mb <= {1'b0, r_mb[31:1]};
                r_mcnt <= r_mcnt + 6'd1;
                if (r_mcnt == 6'd31) r_mbusy <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_last <= i_in.last_item;
                    if (!r_open) begin
                        r_n1 <= i_in.numerator;
                        r_d1 <= {1'b0, i_in.denominator};
                        r_ovf <= 1'b0;
                        r_open <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_n2 <= i_in.numerator;
                        r_d2 <= {1'b0, i_in.denominator};
                        r_ga <= r_d1;
                        r_gb <= {1'b0, i_in.denominator};
                        r_ma <= r_d1; r_mb <= {1'b0, i_in.denominator};
                        r_macc <= '0; r_mcnt <= '0; r_mbusy <= 1'b1;
                        r_state <= S_G1;
                    end
                end
                S_G1: if (r_gb == '0) begin
                    r_g <= r_ga;
                    r_state <= S_MUL1;
                end else begin
                    r_req.a <= r_ga; r_req.b <= r_gb;
                    r_state <= S_G1W;
                end
                S_G1W: if (w_rsp.done) begin
                    r_ga <= r_gb; r_gb <= w_rsp.rem;
                    r_state <= S_G1;
                end
                S_MUL1: if (!r_mbusy) begin
                    r_prod <= r_macc;
                    r_state <= S_LCM;
                end
                S_LCM: begin
                    r_req.a <= r_prod; r_req.b <= r_g;
                    r_state <= S_LCMW;
                end
                S_LCMW: if (w_rsp.done) begin
                    r_lcm <= w_rsp.quo;
                    r_req.a <= w_rsp.quo; r_req.b <= r_d1;
                    r_state <= S_F1W;
                end
                S_F1W: if (w_rsp.done) begin
                    r_f1 <= w_rsp.quo;
                    r_req.a <= r_lcm; r_req.b <= r_d2;
                    r_state <= S_F2W;
                end
                S_F2W: if (w_rsp.done) begin
                    r_f2 <= w_rsp.quo;
                    r_ma <= r_f1; r_mb <= r_n1;
                    r_macc <= '0; r_mcnt <= '0; r_mbusy <= 1'b1;
                    r_state <= S_M2;
                end
                S_M2: if (!r_mbusy) begin
                    r_tmp <= r_macc;
                    r_ma <= r_f2; r_mb <= r_n2;
                    r_macc <= '0; r_mcnt <= '0; r_mbusy <= 1'b1;
                    r_state <= S_M3;
                end
                S_M3: if (!r_mbusy) begin
                    r_num <= r_tmp + r_macc;
                    r_ga <= r_tmp + r_macc;
                    r_gb <= r_lcm;
                    if ($signed(r_tmp + r_macc) < 0 || $signed(r_lcm) < 1) r_ovf <= 1'b1;
                    r_state <= S_G2;
                end
                S_G2: if (r_gb == '0) begin
                    r_g <= r_ga;
                    r_state <= S_DN;
                end else begin
                    r_req.a <= r_ga; r_req.b <= r_gb;
                    r_state <= S_G2W;
                end
                S_G2W: if (w_rsp.done) begin
                    r_ga <= r_gb; r_gb <= w_rsp.rem;
                    r_state <= S_G2;
                end
                S_DN: begin
                    r_req.a <= r_num; r_req.b <= r_g;
                    r_state <= S_DNW;
                end
                S_DNW: if (w_rsp.done) begin
                    r_n1 <= w_rsp.quo;
                    r_req.a <= r_lcm; r_req.b <= r_g;
                    r_state <= S_DDW;
                end
                S_DDW: if (w_rsp.done) begin
                    r_d1 <= w_rsp.quo;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (!r_ovalid) begin
                        r_out.sum_numerator   <= r_n1;
                        r_out.sum_denominator <= r_d1;
                        r_out.overflow        <= r_ovf;
                        r_ovalid <= 1'b1;
                        r_open <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* src/rsa_checker.sv */
module rsa_checker
    import rsa_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result word changed while stalled");
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall |=> !o_out_valid)
        else $error("result word repeated");
    a_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input ready straight after accept");
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result after reset");
endmodule

bind rational_sum_accumulator_top rsa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_out(o_out)
);
